@@ design/werm_pkg.sv @@
// ----------------------------------------------------------------------------
// werm_pkg
// Shared types and constants for the windowed event rate meter.
// ----------------------------------------------------------------------------
package werm_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_ADD   = 1'b1;

    localparam int CNT_W  = 32;
    localparam int TS_W   = 32;
    localparam int RATE_W = 32;
    localparam int DET_W  = 16;

    // count difference times ms per second, before the q24.8 shift
    localparam int MS_W     = 10;
    localparam int PROD_W   = CNT_W + MS_W;
    localparam int FRAC_W   = 8;
    localparam int NUM_HI_W = PROD_W + FRAC_W - RATE_W;

    localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [TS_W-1:0]  ts;
    } t_record;

    typedef struct packed {
        logic                start;
        logic [NUM_HI_W-1:0] num_hi;
        logic [RATE_W-1:0]   num_lo;
        logic [TS_W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ design/werm_if.sv @@
// ----------------------------------------------------------------------------
// werm_if
// Valid/ready channels carrying input items and rate results.
// ----------------------------------------------------------------------------
interface werm_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] num_detections;
    logic [31:0] timestamp_ms;

    modport source (output valid, output action, output num_detections,
                    output timestamp_ms, input ready);
    modport sink   (input valid, input action, input num_detections,
                    input timestamp_ms, output ready);
endinterface

interface werm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rate_per_second;
    logic        window_full;

    modport source (output valid, output rate_per_second, output window_full,
                    input ready);
    modport sink   (input valid, input rate_per_second, input window_full,
                    output ready);
endinterface

@@ design/werm_ring.sv @@
// ----------------------------------------------------------------------------
// werm_ring
// Record ring memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module werm_ring
    import werm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_record       i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_record       o_rd_data
);

    t_record mem [DEPTH];
    t_record r_rd_data;
    logic    r_zero_valid;
    logic    r_rd_blank;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // entry 0 reads as zero until its first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_valid <= 1'b0;
            r_rd_blank   <= 1'b0;
        end else begin
            if (i_wr_en && i_wr_addr == '0) begin
                r_zero_valid <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_blank <= (i_rd_addr == '0) && !r_zero_valid;
            end
        end
    end

    assign o_rd_data = r_rd_blank ? '0 : r_rd_data;

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("ring read and write hit the same entry");

endmodule

@@ design/werm_div.sv @@
// ----------------------------------------------------------------------------
// werm_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
module werm_div
    import werm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(RATE_W);

    logic [TS_W-1:0]   r_rem;
    logic [RATE_W-1:0] r_q;
    logic [TS_W-1:0]   r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TS_W:0]     trial;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_q[RATE_W-1]};
        qbit  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RATE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= TS_W'(i_req.num_hi);
            r_q   <= i_req.num_lo;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= qbit ? TS_W'(trial - {1'b0, r_den}) : trial[TS_W-1:0];
            r_q   <= {r_q[RATE_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

@@ design/windowed_event_rate_meter.sv @@
// ----------------------------------------------------------------------------
// windowed_event_rate_meter
// Ring of {cumulative count, timestamp} records; reports events per second
// between newest and oldest record in unsigned q24.8, saturated.
//
//   port      dir   fields                                       handshake
//   i_item    in    action, num_detections, timestamp_ms         valid/ready
//   o_result  out   rate_per_second, window_full                 valid/ready
//
// one item in flight: accept and ring write, oldest read, difference,
// multiply, bit-serial divide, output load. a zero time difference or a
// saturating quotient skips the divider. reset is synchronous and needs no
// clearing pass. the next item is taken while a result waits in the output
// register.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter
    import werm_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    werm_in_if.sink    i_item,
    werm_out_if.source o_result
);

    localparam int          AW   = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DVW  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_wi, n_wi;
    logic              r_full, n_full;
    logic [CNT_W-1:0]  r_last_count, n_last_count;
    logic [TS_W-1:0]   r_last_ts, n_last_ts;
    logic [CNT_W-1:0]  r_dc;
    logic [TS_W-1:0]   r_dt;
    logic [PROD_W-1:0] r_prod;
    logic [RATE_W-1:0] r_rate;
    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_full;

    logic          in_fire;
    logic          is_add;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_record       wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_record       rd_data;
    t_div_req      div_req;
    t_div_rsp      div_rsp;
    logic          sat;
    logic          out_load;

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign is_add       = (i_item.action == ACT_ADD);

    always_comb begin
        n_last_count = r_last_count;
        n_last_ts    = r_last_ts;
        n_wi         = r_wi;
        n_full       = r_full;
        if (in_fire) begin
            n_last_ts = i_item.timestamp_ms;
            if (is_add) begin
                n_last_count = r_last_count + CNT_W'(i_item.num_detections);
                n_wi         = (r_wi == LAST) ? '0 : r_wi + 1'b1;
                n_full       = r_full || (r_wi == LAST);
            end else begin
                n_last_count = '0;
                n_wi         = AW'(1);
                n_full       = 1'b0;
            end
        end
    end

    assign wr_en         = in_fire;
    assign wr_addr       = is_add ? r_wi : '0;
    assign wr_data.count = n_last_count;
    assign wr_data.ts    = n_last_ts;

    // oldest record: slot 0 until the ring wraps, then the next write slot
    assign rd_en   = (r_state == ST_READ);
    assign rd_addr = r_full ? r_wi : '0;

    werm_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // quotient reaches 2^32 exactly when the high part is not below dt
    assign sat = {{(TS_W-NUM_HI_W){1'b0}}, r_prod[PROD_W-1 -: NUM_HI_W]} >= r_dt;

    assign div_req.start  = (r_state == ST_DIV) && (r_dt != '0) && !sat;
    assign div_req.num_hi = r_prod[PROD_W-1 -: NUM_HI_W];
    assign div_req.num_lo = {r_prod[RATE_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    assign div_req.den    = r_dt;

    werm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_load = (r_state == ST_FIN) && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_WAIT;
            ST_WAIT: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                n_state = div_req.start ? ST_DVW : ST_FIN;
            end
            ST_DVW: begin
                if (div_rsp.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wi         <= AW'(1);
            r_full       <= 1'b0;
            r_last_count <= '0;
            r_last_ts    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wi         <= n_wi;
            r_full       <= n_full;
            r_last_count <= n_last_count;
            r_last_ts    <= n_last_ts;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT) begin
            r_dc <= r_last_count - rd_data.count;
            r_dt <= r_last_ts - rd_data.ts;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_dc) * PROD_W'(MS_PER_SECOND);
        end
        if (r_state == ST_DIV) begin
            if (r_dt == '0) begin
                r_rate <= '0;
            end else if (sat) begin
                r_rate <= '1;
            end
        end
        if (r_state == ST_DVW && div_rsp.done) begin
            r_rate <= div_rsp.quot;
        end
        if (out_load) begin
            r_out_rate <= r_rate;
            r_out_full <= r_full;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.rate_per_second = r_out_rate;
    assign o_result.window_full     = r_out_full;

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_item.action == ACT_START)
            |=> (!r_full && r_wi == AW'(1) && r_last_count == '0))
        else $error("start did not clear the ring state");

    a_zero_dt_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_dt == '0) |-> (r_rate == '0))
        else $error("zero time difference gave a nonzero rate");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_dt != '0 && !sat))
        else $error("divider started on a zero or saturating quotient");

endmodule
